// ===== rtl/trgf_pkg.sv =====
// Shared types and constants of the tape record gap framer.
// Holds result codes, register indexes and the fixed-point scaling constants.
// No dependencies.
package trgf_pkg;

	// Configuration register indexes.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W = 14;
	localparam logic [CFG_INDEX_W-1:0] REG_RECORD_ARMED = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VIDEO_STANDARD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_EOF_GAP_MS = 2'd2;

	localparam logic [CFG_DATA_W-1:0] EOF_GAP_RESET = 14'd3000;

	// Input beat kinds.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	// Video standard codes.
	localparam logic VIDEO_PAL = 1'b0;
	localparam logic VIDEO_NTSC = 1'b1;

	typedef enum logic [1:0] {
		OUT_DATA = 2'd0,
		OUT_REC_END = 2'd1,
		OUT_TAPE_STOP = 2'd2,
		OUT_OVERRUN = 2'd3
	} out_kind_t;

	typedef struct packed {
		out_kind_t out_kind;
		logic [7:0] data_byte;
		logic [15:0] record_gap_ms;
		logic [7:0] byte_index;
		logic [7:0] record_length;
		logic last;
	} result_t;

	// Counter limits.
	localparam logic [11:0] GAP_FRAMES_MAX = 12'd4095;
	localparam logic [9:0] MOTOR_OFF_MAX = 10'd1023;
	localparam logic [11:0] GAP_CLOSE_FRAMES = 12'd2;
	localparam logic [15:0] GAP_MS_MAX = 16'd65535;

	// Gap in ms is frames * lines * 1000 / 15700, which reduces to
	// frames * 3120 / 157 (PAL) or frames * 2620 / 157 (NTSC). It is formed
	// as a multiply by a rounded-up reciprocal and a right shift; the shift
	// is large enough to stay exact for every 12-bit frame count.
	localparam int unsigned GAP_SHIFT = 20;
	localparam int unsigned GAP_K_W = 25;
	localparam logic [GAP_K_W-1:0] GAP_K_PAL =
		GAP_K_W'((64'd3120 * (64'd1 << GAP_SHIFT) + 64'd156) / 64'd157);
	localparam logic [GAP_K_W-1:0] GAP_K_NTSC =
		GAP_K_W'((64'd2620 * (64'd1 << GAP_SHIFT) + 64'd156) / 64'd157);

	// Motor-off frame limit is eof_ms * 157 / 3120 (PAL) or / 2620 (NTSC),
	// exact for every 14-bit setting with this shift.
	localparam int unsigned EOF_SHIFT = 26;
	localparam int unsigned EOF_K_W = 22;
	localparam logic [EOF_K_W-1:0] EOF_K_PAL =
		EOF_K_W'((64'd157 * (64'd1 << EOF_SHIFT) + 64'd3119) / 64'd3120);
	localparam logic [EOF_K_W-1:0] EOF_K_NTSC =
		EOF_K_W'((64'd157 * (64'd1 << EOF_SHIFT) + 64'd2619) / 64'd2620);
	localparam logic [9:0] EOF_LIMIT_RESET = 10'((3000 * 157) / 3120);

endpackage

// ===== rtl/trgf_if.sv =====
// Handshake channels of the tape record gap framer: input beats and results.
// Standalone; no package dependency.
interface trgf_item_if;
	logic valid;
	logic ready;
	logic kind;
	logic [7:0] data_in;
	logic motor_on;
	logic paused;

	modport source(output valid, kind, data_in, motor_on, paused, input ready);
	modport sink(input valid, kind, data_in, motor_on, paused, output ready);
endinterface

interface trgf_result_if;
	logic valid;
	logic ready;
	logic [1:0] out_kind;
	logic [7:0] data_byte;
	logic [15:0] record_gap_ms;
	logic [7:0] byte_index;
	logic [7:0] record_length;
	logic last;

	modport source(output valid, out_kind, data_byte, record_gap_ms, byte_index,
		record_length, last, input ready);
	modport sink(input valid, out_kind, data_byte, record_gap_ms, byte_index,
		record_length, last, output ready);
endinterface

// ===== rtl/tape_record_gap_framer.sv =====
// A beat is registered in the input stage, then processed, and its results are written
// into the result queue, from whose head they are offered on the result channel.
// Throughput: one beat per cycle; a beat that gives two results holds the
// result port for two beats, and input stalls while the 4-entry result queue
// holds more than two results.
// Reset (arst_n low, asynchronous): queue empty, counters zero, tape running.
// Depends on trgf_pkg and the channel interfaces in trgf_if.sv.
module tape_record_gap_framer #(
	parameter int unsigned MAX_RECORD = 132
) (
	input logic clk,
	input logic arst_n,
	trgf_item_if.sink item,
	trgf_result_if.source result,
	input logic cfg_wr_en,
	input logic [trgf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input logic [trgf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import trgf_pkg::*;

	// Record size limit as an 8-bit count, matching the record length fields.
	localparam logic [7:0] MAX_LEN = 8'(MAX_RECORD);
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [QPTR_W:0] QUEUE_ROOM = (QPTR_W+1)'(QUEUE_DEPTH - 2);

	// Configuration registers. The motor-off frame limit is registered from
	// them in the cycle after a write; an item accepted at the earliest right
	// after the write is only processed later still, so it sees it.
	logic armed_q;
	logic video_q;
	logic [CFG_DATA_W-1:0] eof_q;
	logic [9:0] eof_limit_q;
	logic [CFG_DATA_W+EOF_K_W-1:0] eof_prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= 1'b0;
			video_q <= VIDEO_PAL;
			eof_q <= EOF_GAP_RESET;
			eof_limit_q <= EOF_LIMIT_RESET;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_RECORD_ARMED: armed_q <= cfg_data[0];
					REG_VIDEO_STANDARD: video_q <= cfg_data[0];
					REG_EOF_GAP_MS: eof_q <= cfg_data;
					default: ;
				endcase
			end
			eof_limit_q <= eof_prod[EOF_SHIFT +: 10];
		end
	end

	assign eof_prod = (CFG_DATA_W+EOF_K_W)'(eof_q) *
		(CFG_DATA_W+EOF_K_W)'((video_q == VIDEO_NTSC) ? EOF_K_NTSC : EOF_K_PAL);

	// Input register stage. It advances when the result queue has room for
	// the two results that one beat can give at most.
	logic valid_s1;
	logic kind_s1;
	logic [7:0] data_s1;
	logic motor_s1;
	logic paused_s1;
	logic advance;
	logic [QPTR_W:0] count_q;

	assign advance = valid_s1 && (count_q <= QUEUE_ROOM);
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			kind_s1 <= item.kind;
			data_s1 <= item.data_in;
			motor_s1 <= item.motor_on;
			paused_s1 <= item.paused;
		end
	end

	// Framer state.
	logic [11:0] gap_q;
	logic [9:0] motor_off_q;
	logic [7:0] open_len_q;
	logic [15:0] gap_ms_q;
	logic running_q;

	logic [11:0] gap_n;
	logic [9:0] motor_off_n;
	logic [9:0] motor_off_inc;
	logic [7:0] open_len_n;
	logic [7:0] open_len_eff;
	logic [15:0] gap_ms_n;
	logic [15:0] gap_ms_eff;
	logic running_n;

	// Gap scaling: frames times a rounded-up reciprocal, shifted down, then
	// saturated to 16 bits.
	logic [12+GAP_K_W-1:0] gap_prod;
	logic [12+GAP_K_W-GAP_SHIFT-1:0] gap_ms_wide;
	logic [15:0] gap_ms_new;

	assign gap_prod = (12+GAP_K_W)'(gap_q) *
		(12+GAP_K_W)'((video_q == VIDEO_NTSC) ? GAP_K_NTSC : GAP_K_PAL);
	assign gap_ms_wide = gap_prod[12+GAP_K_W-1:GAP_SHIFT];
	assign gap_ms_new = (gap_ms_wide > (12+GAP_K_W-GAP_SHIFT)'(GAP_MS_MAX)) ?
		GAP_MS_MAX : gap_ms_wide[15:0];

	assign motor_off_inc = (motor_off_q < MOTOR_OFF_MAX) ? motor_off_q + 10'd1 :
		motor_off_q;

	result_t res_c [2];
	logic [1:0] n_res;

	always_comb begin
		res_c[0] = '0;
		res_c[1] = '0;
		n_res = 2'd0;
		gap_n = gap_q;
		motor_off_n = motor_off_q;
		open_len_n = open_len_q;
		gap_ms_n = gap_ms_q;
		running_n = running_q;
		open_len_eff = open_len_q;
		gap_ms_eff = gap_ms_q;

		if (kind_s1 == KIND_BYTE) begin
			// Bytes count only while the tape runs, recording is armed and
			// the motor turns.
			if (running_q && armed_q && motor_s1) begin
				// A long enough idle run before this byte closes the open
				// record and latches the gap in front of the new one.
				if (gap_q > GAP_CLOSE_FRAMES) begin
					open_len_eff = 8'd0;
					gap_ms_eff = gap_ms_new;
					if (open_len_q != 8'd0) begin
						res_c[0].out_kind = OUT_REC_END;
						res_c[0].record_gap_ms = gap_ms_q;
						res_c[0].record_length = open_len_q;
						n_res = 2'd1;
					end
				end
				gap_ms_n = gap_ms_eff;
				if (open_len_eff >= MAX_LEN) begin
					// Record full: drop the byte and leave the gap count.
					res_c[n_res[0]].out_kind = OUT_OVERRUN;
					res_c[n_res[0]].record_gap_ms = gap_ms_eff;
					res_c[n_res[0]].record_length = open_len_eff;
					open_len_n = open_len_eff;
				end else begin
					gap_n = 12'd0;
					res_c[n_res[0]].out_kind = OUT_DATA;
					res_c[n_res[0]].data_byte = data_s1;
					res_c[n_res[0]].record_gap_ms = gap_ms_eff;
					res_c[n_res[0]].byte_index = open_len_eff;
					open_len_n = open_len_eff + 8'd1;
				end
				n_res = n_res + 2'd1;
			end
		end else if (!paused_s1) begin
			if (motor_s1) begin
				motor_off_n = 10'd0;
				if (running_q && armed_q && (gap_q < GAP_FRAMES_MAX)) begin
					gap_n = gap_q + 12'd1;
				end
			end else if (running_q && (open_len_q != 8'd0)) begin
				motor_off_n = motor_off_inc;
				// Motor off for too long: end of tape. An unarmed recorder
				// discards the open record.
				if (motor_off_inc > eof_limit_q) begin
					res_c[0].out_kind = OUT_TAPE_STOP;
					res_c[0].record_gap_ms = gap_ms_q;
					if (armed_q) begin
						res_c[0].record_length = open_len_q;
						gap_ms_n = gap_ms_new;
					end
					open_len_n = 8'd0;
					running_n = 1'b0;
					motor_off_n = 10'd0;
					n_res = 2'd1;
				end
			end
		end

		if (n_res == 2'd1) begin
			res_c[0].last = 1'b1;
		end else if (n_res == 2'd2) begin
			res_c[1].last = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= '0;
			motor_off_q <= '0;
			open_len_q <= '0;
			gap_ms_q <= '0;
			running_q <= 1'b1;
		end else if (advance) begin
			gap_q <= gap_n;
			motor_off_q <= motor_off_n;
			open_len_q <= open_len_n;
			gap_ms_q <= gap_ms_n;
			running_q <= running_n;
		end
	end

	// Result queue: up to two writes per cycle, one read beat per cycle.
	result_t queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [1:0] push_n;
	logic pop;
	result_t head;

	assign push_n = advance ? n_res : 2'd0;
	assign pop = result.valid && result.ready;
	assign head = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= res_c[0];
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + QPTR_W'(1)] <= res_c[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + (QPTR_W+1)'(push_n) - (QPTR_W+1)'(pop);
		end
	end

	assign result.valid = (count_q != '0);
	assign result.out_kind = head.out_kind;
	assign result.data_byte = head.data_byte;
	assign result.record_gap_ms = head.record_gap_ms;
	assign result.byte_index = head.byte_index;
	assign result.record_length = head.record_length;
	assign result.last = head.last;

`ifndef SYNTHESIS
	// The queue never holds more entries than it has.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QPTR_W+1)'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	// Once stopped by end of tape, the tape stays stopped until reset.
	assert property (@(posedge clk) disable iff (!arst_n)
		!running_q |=> !running_q)
		else $error("tape restarted without reset");

	// The open record never grows past the size limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		open_len_q <= MAX_LEN)
		else $error("open record exceeds size limit");

	// A processed byte that is recorded restarts the idle frame count.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (kind_s1 == KIND_BYTE) && (n_res != 2'd0) &&
		(res_c[n_res[0] ^ 1'b1].out_kind == OUT_DATA)) |=> (gap_q == 12'd0))
		else $error("gap count not cleared after recorded byte");
`endif

endmodule
